### sv/rvad_pkg.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector package
// Shared widths, defaults and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package rvad_pkg;

   localparam int RAW_W        = 32;
   localparam int SAMPLE_W     = 16;
   localparam int SQ_W         = 31;
   localparam int RAD_W        = 32;
   localparam int VOL_W        = 16;
   localparam int WSAMP_W      = 9;
   localparam int THR_W        = 17;
   localparam int SQRT_STEPS   = 16;

   localparam int WINDOW_MAX_DEFAULT   = 256;
   localparam int SHIFT_AMOUNT_DEFAULT = 14;

   typedef struct packed {
      logic load;
      logic square;
      logic accum;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic emit;
   } rvad_cmd_type;

   typedef struct packed {
      logic window_close;
      logic out_free;
   } rvad_status_type;

endpackage

### sv/rvad_if.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector channels
// Valid/ready interfaces for the sample, result and threshold channels.
// ----------------------------------------------------------------------------
interface rvad_req_if
   import rvad_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [RAW_W-1:0]    raw_word;
   logic                       sample_valid;
   logic                       window_end;

   modport source (output valid, output raw_word, output sample_valid,
                   output window_end, input ready);
   modport sink   (input valid, input raw_word, input sample_valid,
                   input window_end, output ready);
endinterface

interface rvad_rsp_if
   import rvad_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [VOL_W-1:0]     rms_volume;
   logic                 voice_detected;
   logic [WSAMP_W-1:0]   window_samples;

   modport source (output valid, output rms_volume, output voice_detected,
                   output window_samples, input ready);
   modport sink   (input valid, input rms_volume, input voice_detected,
                   input window_samples, output ready);
endinterface

interface rvad_csr_if
   import rvad_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [THR_W-1:0]    data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/rms_voice_activity_detector.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector
// Windowed mean-square energy, integer root and threshold voice flag.
//
// req_bus takes one word per handshake: a raw 32-bit microphone word, a flag
// saying it carries a sample and a flag that closes the window. A window also
// closes once WINDOW_MAX samples are in. Each closed window gives one word on
// rsp_bus: floor root of the truncated mean square, the voice flag (volume
// above threshold) and the sample count. csr_bus writes the signed threshold
// and is always ready; write it only while the block is idle.
// Words are handled one at a time. A word that does not close a window goes
// through load, square and accumulate steps. A closing word then runs a
// one-bit-per-cycle restoring divider over the SUM_W-bit window sum and a
// 16-step digit-by-digit root. The result sits in an output register, so new
// words are taken while it waits; if the receiver stalls, the next closing
// word holds in its final step until the register frees.
// Synchronous reset clears the sum, count, threshold and result valid.
// ----------------------------------------------------------------------------
module rms_voice_activity_detector
   import rvad_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
   parameter int SHIFT_AMOUNT = SHIFT_AMOUNT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   rvad_req_if.sink      req_bus,
   rvad_rsp_if.source    rsp_bus,
   rvad_csr_if.sink      csr_bus
);

   localparam int SUM_W = SQ_W + $clog2(WINDOW_MAX);

   rvad_cmd_type    cmd;
   rvad_status_type status;

   assign csr_bus.ready = 1'b1;

   rvad_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rvad_datapath #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SHIFT_AMOUNT (SHIFT_AMOUNT),
      .SUM_W        (SUM_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .raw_word       (req_bus.raw_word),
      .sample_valid   (req_bus.sample_valid),
      .window_end     (req_bus.window_end),
      .csr_write      (csr_bus.valid),
      .csr_data       (csr_bus.data),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rms_volume     (rsp_bus.rms_volume),
      .voice_detected (rsp_bus.voice_detected),
      .window_samples (rsp_bus.window_samples)
   );

endmodule

### sv/rvad_ctrl.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector controller
// Sequences load, square and accumulate steps per word, and divide, square root and emit steps per closing window.
// ----------------------------------------------------------------------------
module rvad_ctrl
   import rvad_pkg::*;
#(
   parameter int SUM_W = SQ_W + 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  rvad_status_type status,
   output rvad_cmd_type    cmd
);

   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      IDLE,
      SQUARE,
      ACCUM,
      DIVIDE,
      SQRT_INIT,
      SQRT,
      EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ACCUM;
         end
         ACCUM: begin
            cmd.accum = 1'b1;
            step_in   = '0;
            state_in  = status.window_close ? DIVIDE : IDLE;
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = SQRT_INIT;
            end
         end
         SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            step_in       = '0;
            state_in      = SQRT;
         end
         SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### sv/rvad_datapath.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector datapath
// Sample conversion, squaring, window sums, divider, root and result register.
// ----------------------------------------------------------------------------
module rvad_datapath
   import rvad_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEFAULT,
   parameter int SHIFT_AMOUNT = SHIFT_AMOUNT_DEFAULT,
   parameter int SUM_W        = SQ_W + $clog2(WINDOW_MAX_DEFAULT)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rvad_cmd_type             cmd,
   output rvad_status_type          status,
   input  logic signed [RAW_W-1:0]  raw_word,
   input  logic                     sample_valid,
   input  logic                     window_end,
   input  logic                     csr_write,
   input  logic signed [THR_W-1:0]  csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [VOL_W-1:0]         rms_volume,
   output logic                     voice_detected,
   output logic [WSAMP_W-1:0]       window_samples
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   logic signed [THR_W-1:0]     thr_ff;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic                        sample_flag_ff;
   logic                        end_flag_ff;
   logic [SQ_W-1:0]             sq_ff;
   logic [SUM_W-1:0]            sum_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [SUM_W-1:0]            quot_ff;
   logic [CNT_W-1:0]            drem_ff;
   logic [CNT_W-1:0]            divisor_ff;
   logic [RAD_W-1:0]            rad_ff;
   logic [VOL_W:0]              srem_ff;
   logic [VOL_W-1:0]            root_ff;
   logic                        rsp_valid_ff;
   logic [VOL_W-1:0]            vol_ff;
   logic                        voice_ff;
   logic [WSAMP_W-1:0]          wsamp_ff;

   logic signed [RAW_W-1:0]     shifted;
   logic signed [2*SAMPLE_W-1:0] product;
   logic [SUM_W-1:0]            sum_in;
   logic [CNT_W-1:0]            count_in;
   logic                        close;
   logic [CNT_W:0]              drem_sh;
   logic [CNT_W:0]              drem_diff;
   logic                        div_ge;
   logic [VOL_W+2:0]            srem_sh;
   logic [VOL_W+2:0]            trial;
   logic [VOL_W+2:0]            srem_diff;
   logic                        sqrt_ge;
   logic [VOL_W-1:0]            vol_in;
   logic [CNT_W+WSAMP_W-1:0]    count_ext;

   assign shifted  = raw_word >>> SHIFT_AMOUNT;
   assign product  = sample_ff * sample_ff;
   assign sum_in   = sum_ff + (sample_flag_ff ? SUM_W'(sq_ff) : '0);
   assign count_in = count_ff + (sample_flag_ff ? CNT_W'(1) : '0);
   assign close    = end_flag_ff | (sample_flag_ff & (count_in == CNT_W'(WINDOW_MAX)));

   assign drem_sh   = {drem_ff, quot_ff[SUM_W-1]};
   assign div_ge    = drem_sh >= {1'b0, divisor_ff};
   assign drem_diff = drem_sh - {1'b0, divisor_ff};

   assign srem_sh   = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign sqrt_ge   = srem_sh >= trial;
   assign srem_diff = srem_sh - trial;

   assign vol_in    = (divisor_ff == '0) ? '0 : root_ff;
   assign count_ext = {{WSAMP_W{1'b0}}, divisor_ff};

   assign status.window_close = close;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            thr_ff <= csr_data;
         end
         if (cmd.accum) begin
            if (close) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff      <= shifted[SAMPLE_W-1:0];
         sample_flag_ff <= sample_valid;
         end_flag_ff    <= window_end;
      end
      if (cmd.square) begin
         sq_ff <= product[SQ_W-1:0];
      end
      if (cmd.accum) begin
         quot_ff    <= sum_in;
         drem_ff    <= '0;
         divisor_ff <= count_in;
      end
      if (cmd.div_step) begin
         quot_ff <= {quot_ff[SUM_W-2:0], div_ge};
         drem_ff <= div_ge ? drem_diff[CNT_W-1:0] : drem_sh[CNT_W-1:0];
      end
      if (cmd.sqrt_init) begin
         rad_ff  <= {1'b0, quot_ff[SQ_W-1:0]};
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sqrt_ge ? srem_diff[VOL_W:0] : srem_sh[VOL_W:0];
         root_ff <= {root_ff[VOL_W-2:0], sqrt_ge};
      end
      if (cmd.emit) begin
         vol_ff   <= vol_in;
         voice_ff <= $signed({1'b0, vol_in}) > thr_ff;
         wsamp_ff <= count_ext[WSAMP_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rms_volume     = vol_ff;
   assign voice_detected = voice_ff;
   assign window_samples = wsamp_ff;

endmodule

### sv/rvad_checker.sv
// ----------------------------------------------------------------------------
// RMS voice activity detector checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module rvad_checker
   import rvad_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [VOL_W-1:0]    rms_volume,
   input logic                voice_detected,
   input logic [WSAMP_W-1:0]  window_samples
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rms_volume) && $stable(voice_detected) && $stable(window_samples))
      else $error("result word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while first still in work");

endmodule

bind rms_voice_activity_detector rvad_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rms_volume     (rsp_bus.rms_volume),
   .voice_detected (rsp_bus.voice_detected),
   .window_samples (rsp_bus.window_samples)
);
